// ===== design/mdra_pkg.sv =====
package mdra_pkg;

    localparam int MAX_SCREENS = 4;
    localparam int HW_SCREENS  = 4;
    localparam int ACTIVE_MAX  = (MAX_SCREENS < HW_SCREENS) ? MAX_SCREENS : HW_SCREENS;
    localparam int SCR_W       = 2;
    localparam int CNT_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int COORD_W     = 16;
    localparam int SIZE_IN_W   = 16;
    localparam int SIZE_OUT_W  = 17;
    localparam int BOX_W       = 18;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GEOMETRY0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GEOMETRY1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GEOMETRY2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GEOMETRY3    = 3'd5;

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    typedef struct packed {
        logic             load_update;
        logic             load_flush;
        logic             clear_boxes;
        logic [SCR_W-1:0] flush_idx;
    } mdra_cmd_t;

    typedef struct packed {
        logic slot_free;
    } mdra_sts_t;

endpackage

// ===== design/mdra_req_if.sv =====
interface mdra_req_if;
    import mdra_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic signed [COORD_W-1:0]   rect_x;
    logic signed [COORD_W-1:0]   rect_y;
    logic        [SIZE_IN_W-1:0] rect_w;
    logic        [SIZE_IN_W-1:0] rect_h;

    modport source (output valid, input ready, output req_type, rect_x, rect_y, rect_w, rect_h);
    modport sink   (input valid, output ready, input req_type, rect_x, rect_y, rect_w, rect_h);
endinterface

// ===== design/mdra_res_if.sv =====
interface mdra_res_if;
    import mdra_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         result_kind;
    logic        [SCR_W-1:0]      screen_index;
    logic signed [COORD_W-1:0]    out_x;
    logic signed [COORD_W-1:0]    out_y;
    logic        [SIZE_OUT_W-1:0] out_w;
    logic        [SIZE_OUT_W-1:0] out_h;
    logic                         redraw_now;
    logic                         last;

    modport source (output valid, input ready,
                    output result_kind, screen_index, out_x, out_y, out_w, out_h,
                    redraw_now, last);
    modport sink   (input valid, output ready,
                    input result_kind, screen_index, out_x, out_y, out_w, out_h,
                    redraw_now, last);
endinterface

// ===== design/mdra_ctrl.sv =====
module mdra_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_type,
    input  mdra_pkg::mdra_sts_t sts,
    output mdra_pkg::mdra_cmd_t cmd
);
    import mdra_pkg::*;

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_FLUSH = 1'b1;

    localparam logic [SCR_W-1:0] LAST_IDX = SCR_W'(HW_SCREENS - 1);

    logic             state_reg, state_next;
    logic [SCR_W-1:0] idx_reg, idx_next;
    logic             accept;

    assign in_ready = (state_reg == S_IDLE) && sts.slot_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cmd.load_update = 1'b0;
        cmd.load_flush  = 1'b0;
        cmd.clear_boxes = 1'b0;
        cmd.flush_idx   = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_FLUSH)
                    begin
                        state_next = S_FLUSH;
                        idx_next   = '0;
                    end
                    else
                    begin
                        cmd.load_update = 1'b1;
                    end
                end
            end
            S_FLUSH:
            begin
                if (sts.slot_free)
                begin
                    cmd.load_flush = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        cmd.clear_boxes = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== design/mdra_datapath.sv =====
module mdra_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mdra_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mdra_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  mdra_pkg::mdra_cmd_t                   cmd,
    output mdra_pkg::mdra_sts_t                   sts,
    input  logic signed [mdra_pkg::COORD_W-1:0]   rect_x,
    input  logic signed [mdra_pkg::COORD_W-1:0]   rect_y,
    input  logic        [mdra_pkg::SIZE_IN_W-1:0] rect_w,
    input  logic        [mdra_pkg::SIZE_IN_W-1:0] rect_h,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  result_kind,
    output logic        [mdra_pkg::SCR_W-1:0]     screen_index,
    output logic signed [mdra_pkg::COORD_W-1:0]   out_x,
    output logic signed [mdra_pkg::COORD_W-1:0]   out_y,
    output logic       [mdra_pkg::SIZE_OUT_W-1:0] out_w,
    output logic       [mdra_pkg::SIZE_OUT_W-1:0] out_h,
    output logic                                  redraw_now,
    output logic                                  last
);
    import mdra_pkg::*;

    logic [CNT_W-1:0]      count_reg;
    logic [HW_SCREENS-1:0] mask_reg;
    logic [63:0]           geom_reg [HW_SCREENS];

    logic signed [BOX_W-1:0] left_reg   [HW_SCREENS];
    logic signed [BOX_W-1:0] top_reg    [HW_SCREENS];
    logic signed [BOX_W-1:0] right_reg  [HW_SCREENS];
    logic signed [BOX_W-1:0] bottom_reg [HW_SCREENS];
    logic [HW_SCREENS-1:0]   valid_reg;

    logic                         out_valid_reg;
    logic                         kind_reg;
    logic [SCR_W-1:0]             scr_reg;
    logic signed [COORD_W-1:0]    x_reg, y_reg;
    logic [SIZE_OUT_W-1:0]        w_reg, h_reg;
    logic                         redraw_reg, last_reg;

    logic [CNT_W-1:0]        n_active;
    logic [HW_SCREENS-1:0]   hit;
    logic [SCR_W-1:0]        map_scr;
    logic signed [COORD_W-1:0] map_x, map_y;
    logic signed [BOX_W-1:0] bx, by, br, bb;
    logic                    nonempty;
    logic [BOX_W-1:0]        dw [HW_SCREENS];
    logic [BOX_W-1:0]        dh [HW_SCREENS];
    logic [HW_SCREENS-1:0]   emit;
    logic [HW_SCREENS-1:0]   later;
    logic                    found;

    assign n_active = (count_reg > CNT_W'(ACTIVE_MAX)) ? CNT_W'(ACTIVE_MAX) : count_reg;

    always_comb
    begin
        logic signed [BOX_W-1:0] xo, yo, xe, ye, xl, yl;
        for (int i = 0; i < HW_SCREENS; i++)
        begin
            xo = BOX_W'(signed'(geom_reg[i][15:0]));
            yo = BOX_W'(signed'(geom_reg[i][31:16]));
            xl = xo + signed'({2'b00, geom_reg[i][47:32]});
            yl = yo + signed'({2'b00, geom_reg[i][63:48]});
            xe = BOX_W'(rect_x);
            ye = BOX_W'(rect_y);
            hit[i] = (CNT_W'(i) < n_active) && (xo <= xe) && (xe < xl)
                     && (yo <= ye) && (ye < yl);
        end
    end

    always_comb
    begin
        found   = 1'b0;
        map_scr = '0;
        map_x   = rect_x;
        map_y   = rect_y;
        for (int i = 0; i < HW_SCREENS; i++)
        begin
            if (hit[i] && !found)
            begin
                found   = 1'b1;
                map_scr = SCR_W'(i);
                map_x   = rect_x - signed'(geom_reg[i][15:0]);
                map_y   = rect_y - signed'(geom_reg[i][31:16]);
            end
        end
    end

    assign nonempty = (rect_w != '0) && (rect_h != '0);
    assign bx = BOX_W'(map_x);
    assign by = BOX_W'(map_y);
    assign br = bx + signed'({2'b00, rect_w});
    assign bb = by + signed'({2'b00, rect_h});

    always_comb
    begin
        for (int i = 0; i < HW_SCREENS; i++)
        begin
            dw[i]   = BOX_W'(right_reg[i] - left_reg[i]);
            dh[i]   = BOX_W'(bottom_reg[i] - top_reg[i]);
            emit[i] = (CNT_W'(i) < n_active) && !mask_reg[i] && valid_reg[i]
                      && (dw[i] != '0) && (dh[i] != '0);
        end
        later[HW_SCREENS-1] = 1'b0;
        for (int i = HW_SCREENS - 2; i >= 0; i--)
        begin
            later[i] = later[i+1] | emit[i+1];
        end
    end

    assign sts.slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(1);
            mask_reg  <= HW_SCREENS'(1);
            for (int i = 0; i < HW_SCREENS; i++)
            begin
                geom_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SCREEN_COUNT: count_reg   <= cfg_wdata[CNT_W-1:0];
                REG_DEFAULT_MASK: mask_reg    <= cfg_wdata[HW_SCREENS-1:0];
                REG_GEOMETRY0:    geom_reg[0] <= cfg_wdata;
                REG_GEOMETRY1:    geom_reg[1] <= cfg_wdata;
                REG_GEOMETRY2:    geom_reg[2] <= cfg_wdata;
                REG_GEOMETRY3:    geom_reg[3] <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.clear_boxes)
        begin
            valid_reg <= '0;
        end
        else if (cmd.load_update && nonempty)
        begin
            valid_reg[map_scr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_update && nonempty)
        begin
            if (!valid_reg[map_scr] || left_reg[map_scr] > bx)
                left_reg[map_scr] <= bx;
            if (!valid_reg[map_scr] || top_reg[map_scr] > by)
                top_reg[map_scr] <= by;
            if (!valid_reg[map_scr] || right_reg[map_scr] < br)
                right_reg[map_scr] <= br;
            if (!valid_reg[map_scr] || bottom_reg[map_scr] < bb)
                bottom_reg[map_scr] <= bb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_update || (cmd.load_flush && emit[cmd.flush_idx]))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_update)
        begin
            kind_reg   <= KIND_UPDATE;
            scr_reg    <= map_scr;
            x_reg      <= map_x;
            y_reg      <= map_y;
            w_reg      <= SIZE_OUT_W'(rect_w);
            h_reg      <= SIZE_OUT_W'(rect_h);
            redraw_reg <= nonempty && mask_reg[map_scr];
            last_reg   <= 1'b1;
        end
        else if (cmd.load_flush && emit[cmd.flush_idx])
        begin
            kind_reg   <= KIND_FLUSH;
            scr_reg    <= cmd.flush_idx;
            x_reg      <= left_reg[cmd.flush_idx][COORD_W-1:0];
            y_reg      <= top_reg[cmd.flush_idx][COORD_W-1:0];
            w_reg      <= dw[cmd.flush_idx][SIZE_OUT_W-1:0];
            h_reg      <= dh[cmd.flush_idx][SIZE_OUT_W-1:0];
            redraw_reg <= 1'b0;
            last_reg   <= !later[cmd.flush_idx];
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign screen_index = scr_reg;
    assign out_x        = x_reg;
    assign out_y        = y_reg;
    assign out_w        = w_reg;
    assign out_h        = h_reg;
    assign redraw_now   = redraw_reg;
    assign last         = last_reg;

endmodule

// ===== design/multi_screen_dirty_rect_accumulator.sv =====
// Update transaction: one result, registered in the cycle after acceptance; one update per
// cycle while the result register drains. Flush transaction: walks the screens one per cycle
// while the result register drains, emitting up to one dirty box per cycle; no input is
// taken meanwhile. Rate is set by the single result register and the flush screen walk.
// Reset (rst_n, asynchronous, active low): one active screen, screen 0 set in the default mask,
// geometry zero, all dirty boxes empty, result register empty.
module multi_screen_dirty_rect_accumulator (
    input  logic                            clk,
    input  logic                            rst_n,
    mdra_req_if.sink                        req,
    mdra_res_if.source                      res,
    input  logic                            cfg_we,
    input  logic [mdra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mdra_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import mdra_pkg::*;

    mdra_cmd_t cmd;
    mdra_sts_t sts;

    mdra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .req_type (req.req_type),
        .sts      (sts),
        .cmd      (cmd)
    );

    mdra_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .sts          (sts),
        .rect_x       (req.rect_x),
        .rect_y       (req.rect_y),
        .rect_w       (req.rect_w),
        .rect_h       (req.rect_h),
        .out_valid    (res.valid),
        .out_ready    (res.ready),
        .result_kind  (res.result_kind),
        .screen_index (res.screen_index),
        .out_x        (res.out_x),
        .out_y        (res.out_y),
        .out_w        (res.out_w),
        .out_h        (res.out_h),
        .redraw_now   (res.redraw_now),
        .last         (res.last)
    );

endmodule
